// File: rtl/dali_pkg.sv
package dali_pkg;

    localparam int unsigned CFG_COUNT = 8;
    localparam int unsigned CFG_AW    = 5;

    typedef enum logic [2:0] {
        BUS_UNKNOWN    = 3'd0,
        BUS_POWER_DOWN = 3'd1,
        BUS_ERROR      = 3'd2,
        BUS_READY      = 3'd3,
        BUS_TX         = 3'd4,
        BUS_RX         = 3'd5,
        BUS_BREAK      = 3'd6,
        BUS_RECOVERY   = 3'd7
    } t_bus;

    typedef enum logic [2:0] {
        SND_IDLE  = 3'd2,
        SND_START = 3'd3,
        SND_DATA  = 3'd4,
        SND_STOP  = 3'd5
    } t_snd;

    typedef enum logic [2:0] {
        RCV_ERROR = 3'd0,
        RCV_IDLE  = 3'd1,
        RCV_START = 3'd2,
        RCV_DATA  = 3'd3,
        RCV_STOP  = 3'd4
    } t_rcv;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_ERROR   = 3'd1;
    localparam logic [2:0] ST_TIMING  = 3'd2;
    localparam logic [2:0] ST_SEQ     = 3'd3;
    localparam logic [2:0] ST_COLL    = 3'd4;
    localparam logic [2:0] ST_UNKNOWN = 3'd5;

    localparam logic [1:0] KIND_EDGE = 2'd0;
    localparam logic [1:0] KIND_TICK = 2'd1;
    localparam logic [1:0] KIND_SEND = 2'd2;

    localparam logic [1:0] REP_NONE   = 2'd0;
    localparam logic [1:0] REP_RX     = 2'd1;
    localparam logic [1:0] REP_TXDONE = 2'd2;
    localparam logic [1:0] REP_REFUSE = 2'd3;

    localparam logic [CFG_AW-1:0] A_HALF_MIN = 5'd0;
    localparam logic [CFG_AW-1:0] A_HALF_MAX = 5'd4;
    localparam logic [CFG_AW-1:0] A_FULL_MIN = 5'd8;
    localparam logic [CFG_AW-1:0] A_FULL_MAX = 5'd12;
    localparam logic [CFG_AW-1:0] A_STOP     = 5'd16;
    localparam logic [CFG_AW-1:0] A_COLL     = 5'd20;
    localparam logic [CFG_AW-1:0] A_BREAK    = 5'd24;
    localparam logic [CFG_AW-1:0] A_RECOV    = 5'd28;

    localparam logic [31:0] RELOAD_LIMIT  = 32'd600000000;
    localparam logic [31:0] RELOAD_BACK   = 32'd300000000;
    localparam logic [31:0] POWER_DOWN_US = 32'd45000;
    localparam logic [31:0] TX_STOP_US    = 32'd2450;

    typedef struct packed {
        logic [11:0] half_min;
        logic [11:0] half_max;
        logic [11:0] full_min;
        logic [11:0] full_max;
        logic [15:0] stop_time;
        logic [11:0] coll_delta;
        logic [15:0] break_time;
        logic [15:0] recov_time;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] time_us;
        logic        bus_level;
        logic [31:0] send_data;
        logic [5:0]  send_length;
    } t_in;

    typedef struct packed {
        logic        drive_level;
        logic [1:0]  report;
        logic [31:0] frame_bits;
        logic [5:0]  frame_count;
        logic [2:0]  frame_status;
        logic [7:0]  start_gap_ms;
        logic [2:0]  bus_mode;
    } t_out;

endpackage

// File: rtl/dali_if.sv
interface dali_in_if import dali_pkg::*; ();
    logic valid;
    logic ready;
    t_in  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface dali_out_if import dali_pkg::*; ();
    logic valid;
    logic ready;
    t_out data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/dali_cfg.sv
module dali_cfg import dali_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output t_cfg              o_cfg
);
    t_cfg r_cfg;
    logic w;

    assign w      = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{12'd333, 12'd500, 12'd666, 12'd1000, 16'd2400, 12'd100,
                       16'd1200, 16'd4000};
        end else if (w) begin
            unique case (paddr)
                A_HALF_MIN: r_cfg.half_min   <= pwdata[11:0];
                A_HALF_MAX: r_cfg.half_max   <= pwdata[11:0];
                A_FULL_MIN: r_cfg.full_min   <= pwdata[11:0];
                A_FULL_MAX: r_cfg.full_max   <= pwdata[11:0];
                A_STOP:     r_cfg.stop_time  <= pwdata[15:0];
                A_COLL:     r_cfg.coll_delta <= pwdata[11:0];
                A_BREAK:    r_cfg.break_time <= pwdata[15:0];
                A_RECOV:    r_cfg.recov_time <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr)
            A_HALF_MIN: prdata = {20'd0, r_cfg.half_min};
            A_HALF_MAX: prdata = {20'd0, r_cfg.half_max};
            A_FULL_MIN: prdata = {20'd0, r_cfg.full_min};
            A_FULL_MAX: prdata = {20'd0, r_cfg.full_max};
            A_STOP:     prdata = {16'd0, r_cfg.stop_time};
            A_COLL:     prdata = {20'd0, r_cfg.coll_delta};
            A_BREAK:    prdata = {16'd0, r_cfg.break_time};
            A_RECOV:    prdata = {16'd0, r_cfg.recov_time};
            default:    prdata = 32'd0;
        endcase
    end
endmodule

// File: rtl/dali_core.sv
module dali_core import dali_pkg::*; #(
    parameter int unsigned MAX_FRAME_BITS = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_go,
    input  t_in  i_item,
    input  t_cfg i_cfg,
    output t_out o_res
);
    localparam logic [5:0] RX_LIMIT = (MAX_FRAME_BITS < 32) ? 6'(MAX_FRAME_BITS) : 6'd32;

    t_bus r_bus, n_bus;
    t_snd r_snd, n_snd;
    t_rcv r_rcv, n_rcv;
    logic [31:0] r_lrx, n_lrx, r_ltx, n_ltx;
    logic r_line, n_line, r_drv, n_drv;
    logic [31:0] r_txf, n_txf;
    logic [5:0]  r_txc, n_txc;
    logic [2:0]  r_txs, n_txs;
    logic [7:0]  r_txh, n_txh;
    logic [5:0]  r_txb, n_txb;
    logic [31:0] r_rxf, n_rxf;
    logic [5:0]  r_rxb, n_rxb;
    logic [7:0]  r_rxh, n_rxh;
    logic [2:0]  r_rxs, n_rxs;
    logic [7:0]  r_gap, n_gap;
    logic        r_pv, n_pv;
    logic [31:0] r_pf, n_pf;
    logic [5:0]  r_pc, n_pc;

    logic [31:0] t, pw, dtx;
    logic        lvl;
    logic [5:0]  slen;
    logic [31:0] ms;
    logic [1:0]  rep;
    logic        txv, rx_one, done;
    t_out        res;

    assign t    = i_item.time_us;
    assign lvl  = i_item.bus_level;
    assign pw   = t - r_lrx;
    assign dtx  = t - r_ltx;
    assign slen = (i_item.send_length > 6'd32) ? 6'd32 : i_item.send_length;
    // Divide by 1000 only matters up to 255 ms; above that the gap saturates.
    // The quotient is (pw / 8) / 125, the last step by reciprocal multiplication.
    assign ms   = (pw >= 32'd256000) ? 32'd255 : (((pw >> 3) * 32'd33555) >> 22);

    always_comb begin
        n_bus = r_bus; n_snd = r_snd; n_rcv = r_rcv;
        n_lrx = r_lrx; n_ltx = r_ltx; n_line = r_line; n_drv = r_drv;
        n_txf = r_txf; n_txc = r_txc; n_txs = r_txs; n_txh = r_txh; n_txb = r_txb;
        n_rxf = r_rxf; n_rxb = r_rxb; n_rxh = r_rxh; n_rxs = r_rxs; n_gap = r_gap;
        n_pv = r_pv; n_pf = r_pf; n_pc = r_pc;
        rep = REP_NONE; txv = 1'b0; rx_one = 1'b0; done = 1'b0;
        res = '0;
        case (i_item.kind)
            KIND_EDGE: begin
                n_line = lvl;
                n_lrx  = t;
                if (r_bus == BUS_READY && !lvl) begin
                    n_gap = ms[7:0];
                    n_rxf = '0; n_rxs = ST_UNKNOWN; n_rcv = RCV_START; n_bus = BUS_RX;
                    n_rxh = '0; n_rxb = '0;
                end else if (r_bus == BUS_RX) begin
                    if (r_rcv == RCV_START) begin
                        if (lvl && pw > 32'(i_cfg.half_min) && pw < 32'(i_cfg.half_max)) begin
                            n_rcv = RCV_DATA; n_rxh = r_rxh + 8'd1;
                        end else begin
                            n_bus = BUS_ERROR; n_rxs = ST_TIMING;
                        end
                    end else if (r_rcv == RCV_DATA) begin
                        rx_one = !r_line && lvl;
                        if (r_line == lvl) begin
                            n_rcv = RCV_ERROR; n_rxs = ST_SEQ;
                        end else if (pw > 32'(i_cfg.full_min) && pw < 32'(i_cfg.full_max))
                        begin
                            if (!r_rxh[0]) begin
                                n_rcv = RCV_ERROR;
                            end else begin
                                if (rx_one && r_rxb < 6'd32)
                                    n_rxf[5'd31 - r_rxb[4:0]] = 1'b1;
                                n_rxh = r_rxh + 8'd2;
                                n_rxb = r_rxb + 6'd1;
                                done = 1'b1;
                            end
                        end else if (pw > 32'(i_cfg.half_min) && pw < 32'(i_cfg.half_max))
                        begin
                            if (!r_rxh[0]) begin
                                if (rx_one && r_rxb < 6'd32)
                                    n_rxf[5'd31 - r_rxb[4:0]] = 1'b1;
                                n_rxb = r_rxb + 6'd1;
                            end
                            n_rxh = r_rxh + 8'd1;
                            done = 1'b1;
                        end else begin
                            n_rxs = ST_TIMING; n_rcv = RCV_ERROR;
                        end
                        if (done && n_rxb >= RX_LIMIT) n_rcv = RCV_STOP;
                    end
                end else if (r_bus == BUS_TX && dtx > 32'(i_cfg.coll_delta)) begin
                    n_drv = 1'b0; n_ltx = t; n_bus = BUS_BREAK; n_txs = ST_COLL;
                end else if (r_bus == BUS_RECOVERY) begin
                    n_bus = BUS_ERROR;
                end
            end
            KIND_TICK: begin
                if (pw > RELOAD_LIMIT) n_lrx = t - RELOAD_BACK;
                if (dtx > RELOAD_LIMIT) n_ltx = t - RELOAD_BACK;
                if (r_bus <= BUS_ERROR && r_line && pw > 32'(i_cfg.stop_time))
                    n_bus = BUS_READY;
                if (!r_line && pw > POWER_DOWN_US) begin
                    n_bus = BUS_POWER_DOWN; n_drv = 1'b1;
                end
                if (n_bus == BUS_BREAK && pw > 32'(i_cfg.break_time)) begin
                    n_drv = 1'b1; n_ltx = t;
                    n_bus = lvl ? BUS_RECOVERY : BUS_ERROR;
                end else if (n_bus == BUS_RECOVERY && pw > 32'(i_cfg.recov_time)) begin
                    n_bus = BUS_READY;
                end else if (n_bus == BUS_READY && r_snd == SND_IDLE && r_pv) begin
                    n_txf = r_pf; n_txc = r_pc; n_pv = 1'b0; n_txs = ST_ERROR;
                    n_bus = BUS_TX; n_snd = SND_START; n_txh = '0; n_txb = '0;
                    n_drv = 1'b0; n_ltx = t;
                end else if (n_bus == BUS_TX) begin
                    if (r_snd == SND_START) begin
                        n_snd = SND_DATA; n_txh = r_txh + 8'd1; n_drv = 1'b1; n_ltx = t;
                    end else if (r_snd == SND_DATA) begin
                        txv = (r_txb < 6'd32) ? r_txf[5'd31 - r_txb[4:0]] : 1'b0;
                        n_drv = txv ^ r_txh[0];
                        n_ltx = t;
                        n_txh = r_txh + 8'd1;
                        if (n_txh[0]) begin
                            n_txb = r_txb + 6'd1;
                            if (n_txb >= r_txc) n_snd = SND_STOP;
                        end
                    end else if (r_snd == SND_STOP) begin
                        if (!r_drv) begin
                            n_drv = 1'b1; n_ltx = t;
                        end else if (dtx > TX_STOP_US) begin
                            n_txs = ST_OK; rep = REP_TXDONE; n_snd = SND_IDLE;
                            n_bus = BUS_READY;
                        end
                    end
                end else if (n_bus == BUS_READY && r_snd > SND_IDLE) begin
                    rep = REP_TXDONE; n_snd = SND_IDLE;
                end
                if (n_bus == BUS_RX && pw > 32'(i_cfg.stop_time)) begin
                    if (r_rcv == RCV_ERROR) begin
                        n_rcv = RCV_IDLE; n_bus = BUS_READY; rep = REP_RX;
                    end else if (r_rcv == RCV_DATA || r_rcv == RCV_STOP) begin
                        n_rcv = RCV_IDLE; n_bus = BUS_READY; n_rxs = ST_OK; rep = REP_RX;
                    end
                end
                if (rep == REP_RX) begin
                    res.frame_bits = n_rxf; res.frame_count = n_rxb;
                    res.frame_status = n_rxs; res.start_gap_ms = n_gap;
                end else if (rep == REP_TXDONE) begin
                    res.frame_bits = n_txf; res.frame_count = n_txc;
                    res.frame_status = n_txs;
                end
            end
            KIND_SEND: begin
                if (r_pv) begin
                    rep = REP_REFUSE; res.frame_bits = i_item.send_data;
                    res.frame_count = slen; res.frame_status = ST_ERROR;
                end else begin
                    n_pv = 1'b1; n_pf = i_item.send_data; n_pc = slen;
                end
            end
            default: ;
        endcase
        res.report      = rep;
        res.drive_level = n_drv;
        res.bus_mode    = n_bus;
    end

    assign o_res = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bus <= BUS_UNKNOWN; r_snd <= SND_IDLE; r_rcv <= RCV_IDLE;
            r_lrx <= '0; r_ltx <= '0; r_line <= 1'b0; r_drv <= 1'b1;
            r_txf <= '0; r_txc <= '0; r_txs <= '0; r_txh <= '0; r_txb <= '0;
            r_rxf <= '0; r_rxb <= '0; r_rxh <= '0; r_rxs <= ST_UNKNOWN; r_gap <= '0;
            r_pv <= 1'b0; r_pf <= '0; r_pc <= '0;
        end else if (i_go) begin
            r_bus <= n_bus; r_snd <= n_snd; r_rcv <= n_rcv;
            r_lrx <= n_lrx; r_ltx <= n_ltx; r_line <= n_line; r_drv <= n_drv;
            r_txf <= n_txf; r_txc <= n_txc; r_txs <= n_txs; r_txh <= n_txh; r_txb <= n_txb;
            r_rxf <= n_rxf; r_rxb <= n_rxb; r_rxh <= n_rxh; r_rxs <= n_rxs; r_gap <= n_gap;
            r_pv <= n_pv; r_pf <= n_pf; r_pc <= n_pc;
        end
    end
endmodule

// File: rtl/dali_manchester_bus_controller_top.sv
// Channel   Direction  Payload
// in        sink       kind, time_us, bus_level, send_data, send_length
// out       source     drive_level, report, frame_bits, frame_count, frame_status,
//                      start_gap_ms, bus_mode
// apb       slave      eight configuration registers at 4*i
// A word is registered at the input, handled by the controller combinationally and
// its result registered at the output; one word can enter every cycle while the
// output is not stalled. The state update of one word is one combinational pass.
// Reset is synchronous, active low; it restores register defaults and state.
// A stalled output holds its word; input stalls only when both stages are full.
module dali_manchester_bus_controller_top import dali_pkg::*; #(
    parameter int unsigned MAX_FRAME_BITS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    dali_in_if.sink           in_ch,
    dali_out_if.source        out_ch,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    t_cfg cfg;
    logic r_iv, r_ov, go;
    t_in  r_in;
    t_out r_out, res;

    dali_cfg u_cfg (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
        .prdata, .pready, .o_cfg(cfg)
    );

    dali_core #(.MAX_FRAME_BITS(MAX_FRAME_BITS)) u_core (
        .i_clk, .i_rst_n, .i_go(go), .i_item(r_in), .i_cfg(cfg), .o_res(res)
    );

    assign go          = r_iv && (!r_ov || out_ch.ready);
    assign in_ch.ready = !r_iv || go;
    assign out_ch.valid = r_ov;
    assign out_ch.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iv <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (in_ch.ready) r_iv <= in_ch.valid;
            if (go) r_ov <= 1'b1;
            else if (out_ch.ready) r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ch.ready && in_ch.valid) r_in <= in_ch.data;
        if (go) r_out <= res;
    end
endmodule

// File: rtl/dali_chk.sv
module dali_chk import dali_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input t_out out_data
);
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && !in_ready |=> in_valid)
        else $error("input word withdrawn while waiting");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled output word changed");
    a_refuse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_data.report == REP_REFUSE |-> out_data.frame_status == ST_ERROR)
        else $error("refused send without error status");
    a_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_data.report != REP_RX |-> out_data.start_gap_ms == 8'd0)
        else $error("gap shown outside a received frame");
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> out_data.frame_count <= 6'd32)
        else $error("frame count out of range");
endmodule

bind dali_manchester_bus_controller_top dali_chk u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);

// File: tb/sv/dali_manchester_bus_controller_top_test.sv
module dali_manchester_bus_controller_top_test;
    import dali_pkg::*;

    // Tracks the controller state and holds the words it should report.
    class dali_scoreboard;
        logic [15:0] cfg_val [CFG_COUNT];
        t_bus        bus;
        t_snd        snd;
        t_rcv        rcv;
        logic [31:0] last_rx, last_tx;
        logic        line, drive;
        logic [31:0] tx_frame, rx_frame, pend_frame;
        logic [5:0]  tx_count, tx_bit, rx_bit, pend_count;
        logic [7:0]  tx_half, rx_half, rx_gap;
        logic [2:0]  tx_status, rx_status;
        logic        pend_valid;
        t_out        result_q [$];
        int          mismatches;
        int          n_rx, n_txdone, n_refused, n_checked;

        function new();
            cfg_val = '{16'd333, 16'd500, 16'd666, 16'd1000, 16'd2400, 16'd100, 16'd1200,
                        16'd4000};
            bus = BUS_UNKNOWN; snd = SND_IDLE; rcv = RCV_IDLE;
            last_rx = '0; last_tx = '0; line = 1'b0; drive = 1'b1;
            tx_frame = '0; tx_count = '0; tx_status = ST_OK; tx_half = '0; tx_bit = '0;
            rx_frame = '0; rx_bit = '0; rx_half = '0; rx_status = ST_UNKNOWN; rx_gap = '0;
            pend_valid = 1'b0; pend_frame = '0; pend_count = '0;
            mismatches = 0; n_rx = 0; n_txdone = 0; n_refused = 0; n_checked = 0;
        endfunction

        function bit in_win(logic [31:0] x, logic [15:0] lo, logic [15:0] hi);
            return x > lo && x < hi;
        endfunction

        function void mark_one();
            if (rx_bit < 32) rx_frame[31 - rx_bit] = 1'b1;
        endfunction

        function void take_edge(logic [31:0] t, logic lvl);
            logic        prev;
            logic [31:0] pw, dtx, ms;
            prev = line; pw = t - last_rx; dtx = t - last_tx;
            line = lvl; last_rx = t;
            if (bus == BUS_READY && !lvl) begin
                ms = pw / 1000;
                rx_gap = (ms > 255) ? 8'd255 : ms[7:0];
                rx_frame = '0; rx_status = ST_UNKNOWN; rcv = RCV_START; bus = BUS_RX;
                rx_half = '0; rx_bit = '0;
            end else if (bus == BUS_RX) begin
                if (rcv == RCV_START) begin
                    if (lvl && in_win(pw, cfg_val[0], cfg_val[1])) begin
                        rcv = RCV_DATA; rx_half = rx_half + 8'd1;
                    end else begin
                        bus = BUS_ERROR; rx_status = ST_TIMING;
                    end
                end else if (rcv == RCV_DATA) begin
                    if (prev == lvl) begin
                        rcv = RCV_ERROR; rx_status = ST_SEQ; return;
                    end
                    if (in_win(pw, cfg_val[2], cfg_val[3])) begin
                        if (!rx_half[0]) begin
                            rcv = RCV_ERROR; return;
                        end
                        if (!prev && lvl) mark_one();
                        rx_half = rx_half + 8'd2; rx_bit = rx_bit + 6'd1;
                    end else if (in_win(pw, cfg_val[0], cfg_val[1])) begin
                        if (!rx_half[0]) begin
                            if (!prev && lvl) mark_one();
                            rx_bit = rx_bit + 6'd1;
                        end
                        rx_half = rx_half + 8'd1;
                    end else begin
                        rx_status = ST_TIMING; rcv = RCV_ERROR; return;
                    end
                    if (rx_bit >= 32) rcv = RCV_STOP;
                end
            end else if (bus == BUS_TX && dtx > cfg_val[5]) begin
                drive = 1'b0; last_tx = t; bus = BUS_BREAK; tx_status = ST_COLL;
            end else if (bus == BUS_RECOVERY) begin
                bus = BUS_ERROR;
            end
        endfunction

        function logic [1:0] take_tick(logic [31:0] t, logic lvl);
            logic [31:0] rxd, txd;
            logic [1:0]  rep;
            logic        v;
            rxd = t - last_rx; txd = t - last_tx; rep = REP_NONE;
            if (rxd > RELOAD_LIMIT) last_rx = t - RELOAD_BACK;
            if (txd > RELOAD_LIMIT) last_tx = t - RELOAD_BACK;
            if (bus <= BUS_ERROR && line && rxd > cfg_val[4]) bus = BUS_READY;
            if (!line && rxd > POWER_DOWN_US) begin
                bus = BUS_POWER_DOWN; drive = 1'b1;
            end
            if (bus == BUS_BREAK && rxd > cfg_val[6]) begin
                drive = 1'b1; last_tx = t;
                bus = lvl ? BUS_RECOVERY : BUS_ERROR;
            end else if (bus == BUS_RECOVERY && rxd > cfg_val[7]) begin
                bus = BUS_READY;
            end else if (bus == BUS_READY && snd == SND_IDLE && pend_valid) begin
                tx_frame = pend_frame; tx_count = pend_count; pend_valid = 1'b0;
                tx_status = ST_ERROR; bus = BUS_TX; snd = SND_START;
                tx_half = '0; tx_bit = '0; drive = 1'b0; last_tx = t;
            end else if (bus == BUS_TX) begin
                if (snd == SND_START) begin
                    snd = SND_DATA; tx_half = tx_half + 8'd1; drive = 1'b1; last_tx = t;
                end else if (snd == SND_DATA) begin
                    v = (tx_bit < 32) ? tx_frame[31 - tx_bit] : 1'b0;
                    drive = v ^ tx_half[0]; last_tx = t;
                    tx_half = tx_half + 8'd1;
                    if (tx_half[0]) begin
                        tx_bit = tx_bit + 6'd1;
                        if (tx_bit >= tx_count) snd = SND_STOP;
                    end
                end else if (snd == SND_STOP) begin
                    if (!drive) begin
                        drive = 1'b1; last_tx = t;
                    end else if (txd > TX_STOP_US) begin
                        tx_status = ST_OK; rep = REP_TXDONE; snd = SND_IDLE; bus = BUS_READY;
                    end
                end
            end else if (bus == BUS_READY && snd > SND_IDLE) begin
                rep = REP_TXDONE; snd = SND_IDLE;
            end
            if (bus == BUS_RX && rxd > cfg_val[4]) begin
                if (rcv == RCV_ERROR) begin
                    rcv = RCV_IDLE; bus = BUS_READY; rep = REP_RX;
                end else if (rcv == RCV_DATA || rcv == RCV_STOP) begin
                    rcv = RCV_IDLE; bus = BUS_READY; rx_status = ST_OK; rep = REP_RX;
                end
            end
            return rep;
        endfunction

        function void note_input(t_in w);
            t_out       r;
            logic [5:0] len;
            r = '0;
            len = (w.send_length > 32) ? 6'd32 : w.send_length;
            if (w.kind == KIND_EDGE) begin
                take_edge(w.time_us, w.bus_level);
            end else if (w.kind == KIND_TICK) begin
                r.report = take_tick(w.time_us, w.bus_level);
                if (r.report == REP_RX) begin
                    r.frame_bits = rx_frame; r.frame_count = rx_bit;
                    r.frame_status = rx_status; r.start_gap_ms = rx_gap; n_rx++;
                end else if (r.report == REP_TXDONE) begin
                    r.frame_bits = tx_frame; r.frame_count = tx_count;
                    r.frame_status = tx_status; n_txdone++;
                end
            end else if (w.kind == KIND_SEND) begin
                if (pend_valid) begin
                    r.report = REP_REFUSE; r.frame_bits = w.send_data; r.frame_count = len;
                    r.frame_status = ST_ERROR; n_refused++;
                end else begin
                    pend_valid = 1'b1; pend_frame = w.send_data; pend_count = len;
                end
            end
            r.drive_level = drive;
            r.bus_mode = bus;
            result_q.push_back(r);
        endfunction

        function void check_result(t_out got);
            t_out e;
            if (result_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected word %h", got);
                return;
            end
            e = result_q.pop_front();
            n_checked++;
            if (got.drive_level !== e.drive_level || got.report !== e.report ||
                got.frame_bits !== e.frame_bits || got.frame_count !== e.frame_count ||
                got.frame_status !== e.frame_status || got.start_gap_ms !== e.start_gap_ms ||
                got.bus_mode !== e.bus_mode) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: drive %b/%b report %0d/%0d bits %h/%h count %0d/%0d",
                        e.drive_level, got.drive_level, e.report, got.report, e.frame_bits,
                        got.frame_bits, e.frame_count, got.frame_count,
                        "\n          status %0d/%0d gap %0d/%0d mode %0d/%0d",
                        e.frame_status, got.frame_status, e.start_gap_ms, got.start_gap_ms,
                        e.bus_mode, got.bus_mode);
            end
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [CFG_AW-1:0] paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;

    dali_in_if  in_ch ();
    dali_out_if out_ch ();

    dali_manchester_bus_controller_top DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    dali_scoreboard sb = new();
    logic [31:0]    now_us;
    int             words_sent = 0;
    bit             idle_on = 1'b1;
    int             sink_stall = 0;

    always #10 i_clk = ~i_clk;

    initial begin
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
    end

    always @(posedge i_clk) begin
        if (sink_stall > 0) begin
            out_ch.ready <= 1'b0;
            sink_stall <= sink_stall - 1;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            out_ch.ready <= 1'b0;
            sink_stall <= $urandom_range(0, 3);
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk)
        if (i_rst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);

    task automatic put_word(t_in w);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= w;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_input(w);
        words_sent++;
    endtask

    task automatic event_at(logic [1:0] kind, logic [31:0] dt, logic lvl,
                            logic [31:0] sdata = '0, logic [5:0] slen = '0);
        t_in w;
        now_us = now_us + dt;
        w.kind = kind; w.time_us = now_us; w.bus_level = lvl;
        w.send_data = sdata; w.send_length = slen;
        put_word(w);
    endtask

    // Brings the line high and waits past the stop time so the bus settles to ready.
    task automatic settle_bus();
        event_at(KIND_EDGE, $urandom_range(5, 50), 1'b1, $urandom, 6'($urandom));
        event_at(KIND_TICK, sb.cfg_val[4] + 1 + $urandom_range(0, 3000), 1'b1);
    endtask

    task automatic receive_frame(int nbits);
        logic        halves [$];
        logic        b, cur;
        int          run;
        logic [31:0] hw, fw, dt;
        hw = (sb.cfg_val[0] + sb.cfg_val[1]) / 2;
        fw = (sb.cfg_val[2] + sb.cfg_val[3]) / 2;
        settle_bus();
        halves.push_back(1'b0);
        halves.push_back(1'b1);
        for (int i = 0; i < nbits; i++) begin
            b = 1'($urandom_range(0, 1));
            halves.push_back(~b);
            halves.push_back(b);
        end
        // The start edge comes after an idle gap that sometimes saturates.
        dt = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 400000) : $urandom_range(1, 20000);
        event_at(KIND_EDGE, dt, 1'b0);
        cur = 1'b0;
        run = 1;
        for (int i = 1; i < halves.size(); i++) begin
            if (halves[i] == cur) begin
                run++;
            end else begin
                dt = (run == 1) ? hw : fw;
                if ($urandom_range(0, 40) == 0) dt = $urandom_range(0, 1500);
                dt = dt + $urandom_range(0, 20) - 10;
                event_at(KIND_EDGE, dt, halves[i]);
                cur = halves[i];
                run = 1;
            end
        end
        if (!cur) event_at(KIND_EDGE, hw, 1'b1);
        event_at(KIND_TICK, sb.cfg_val[4] + 1 + $urandom_range(0, 500), 1'b1);
    endtask

    task automatic send_frame(logic [31:0] sdata, logic [5:0] slen);
        int          nticks;
        logic [31:0] echo;
        settle_bus();
        event_at(KIND_SEND, $urandom_range(0, 100), 1'b1, sdata, slen);
        if ($urandom_range(0, 3) == 0)
            event_at(KIND_SEND, $urandom_range(0, 100), 1'b1, $urandom, 6'($urandom));
        nticks = 2 * ((slen > 32) ? 32 : slen) + 8;
        for (int i = 0; i < nticks; i++) begin
            echo = 0;
            event_at(KIND_TICK, 416, sb.drive);
            if ($urandom_range(0, 1) == 0) begin
                echo = ($urandom_range(0, 30) == 0) ? $urandom_range(100, 400)
                                                   : $urandom_range(1, 90);
                event_at(KIND_EDGE, echo, sb.drive);
            end
            now_us = now_us - echo;
        end
        // Long gaps let a finished frame report, or a break and recovery run out.
        for (int i = 0; i < 3; i++)
            event_at(KIND_TICK, 2500 + $urandom_range(0, sb.cfg_val[7] / 2), $urandom_range(0, 3) != 0);
    endtask

    task automatic noise(int n);
        logic [31:0] dt;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 9))
                0: dt = $urandom;
                1: dt = 46000 + $urandom_range(0, 10000);
                default: dt = $urandom_range(0, 5000);
            endcase
            event_at(2'($urandom_range(0, 3)), dt, 1'($urandom_range(0, 1)), $urandom,
                     6'($urandom_range(0, 63)));
        end
    endtask

    task automatic write_reg(logic [CFG_AW-1:0] idx, logic [15:0] val);
        @(posedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= {idx[2:0], 2'b00}; pwdata <= {16'($urandom), val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        sb.cfg_val[idx] = (idx == 4 || idx >= 6) ? val : {4'd0, val[11:0]};
    endtask

    task automatic load_config(logic [15:0] v [CFG_COUNT]);
        in_ch.valid <= 1'b0;
        wait (sb.result_q.size() == 0);
        repeat (4) @(posedge i_clk);
        for (int i = 0; i < CFG_COUNT; i++) write_reg(CFG_AW'(i), v[i]);
    endtask

    task automatic random_part(int upto);
        while (words_sent < upto) begin
            idle_on = words_sent < 1150;
            case ($urandom_range(0, 9))
                0, 1, 2, 3: receive_frame(($urandom_range(0, 7) == 0) ? $urandom_range(0, 34)
                                                                      : $urandom_range(8, 25));
                4, 5, 6: send_frame($urandom, 6'(($urandom_range(0, 7) == 0)
                                               ? $urandom_range(0, 63) : $urandom_range(1, 24)));
                default: noise($urandom_range(3, 8));
            endcase
        end
    endtask

    initial begin
        logic [15:0] v [CFG_COUNT];
        now_us = $urandom;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: odd kinds, length and data extremes, a refused send, wrap of time.
        event_at(2'd3, 0, 1'b1, 32'hFFFF_FFFF, 6'd63);
        event_at(KIND_TICK, 32'hFFFF_FFFF, 1'b0);
        event_at(KIND_SEND, 1, 1'b1, 32'hFFFF_FFFF, 6'd63);
        event_at(KIND_SEND, 1, 1'b0, 32'h0000_0000, 6'd0);
        event_at(KIND_TICK, 46001, 1'b0);
        send_frame(32'hA5A5_5A5A, 6'd0);
        receive_frame(34);
        noise(4);

        random_part(450);
        v = '{16'd300, 16'd520, 16'd640, 16'd1040, 16'd3000, 16'd60, 16'd900, 16'd2000};
        load_config(v);
        random_part(800);
        v = '{16'd0, 16'hFFF, 16'd0, 16'hFFF, 16'hFFFF, 16'hFFF, 16'hFFFF, 16'hFFFF};
        load_config(v);
        random_part(950);
        v = '{16'd333, 16'd500, 16'd666, 16'd1000, 16'd0, 16'd0, 16'd0, 16'd0};
        load_config(v);
        random_part(1300);
        in_ch.valid <= 1'b0;

        wait (sb.result_q.size() == 0);
        repeat (10) @(posedge i_clk);
        $display("covered %0d words: %0d received frames, %0d finished sends, %0d refused",
                 words_sent, sb.n_rx, sb.n_txdone, sb.n_refused);
        $display("%0d results checked, %0d mismatches", sb.n_checked, sb.mismatches);
        if (sb.mismatches == 0 && sb.result_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #200000000;
        $display("status: fail");
        $finish;
    end
endmodule

// File: filelist.f
rtl/dali_pkg.sv
rtl/dali_if.sv
rtl/dali_cfg.sv
rtl/dali_core.sv
rtl/dali_manchester_bus_controller_top.sv
rtl/dali_chk.sv
tb/sv/dali_manchester_bus_controller_top_test.sv
